>>> rtl/rfmc_pkg.sv
`default_nettype none
package rfmc_pkg;

    // coordinate width in bits, signed millimetres
    localparam int COORD_WIDTH = 16;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] robot_x;
        logic signed [COORD_WIDTH-1:0] robot_y;
        logic signed [15:0]            robot_heading;
        logic signed [COORD_WIDTH-1:0] goal_x;
        logic signed [COORD_WIDTH-1:0] goal_y;
        logic signed [COORD_WIDTH-1:0] face_x;
        logic signed [COORD_WIDTH-1:0] face_y;
        logic                          kick_request;
        logic                          team_yellow;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] vel_forward;
        logic signed [15:0] vel_side;
        logic signed [15:0] turn_rate;
        logic [7:0]         kick_power;
        logic               team_out;
    } out_word_t;

    localparam int ATAN_ENTRIES = 24;
    localparam logic [2:0] REG_MOVE_PLAIN = 3'd0;
    localparam logic [2:0] REG_MOVE_KICK  = 3'd1;
    localparam logic [2:0] REG_TURN_PLAIN = 3'd2;
    localparam logic [2:0] REG_TURN_KICK  = 3'd3;
    localparam logic [2:0] REG_KICK_POWER = 3'd4;

    localparam logic signed [17:0] INV_GAIN_Q16 = 18'sd39797;
    localparam logic signed [31:0] PI_Q29 = 32'sd1686629713;

    function automatic logic [31:0] atan_entry(input int i);
        logic [31:0] r;
        begin
            unique case (i)
                0: r = 32'h20000000;  1: r = 32'h12E4051D;  2: r = 32'h09FB385B;
                3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
                6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
                9: r = 32'h00145F2E;  10: r = 32'h000A2F98; 11: r = 32'h000517CC;
                12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2F9;
                15: r = 32'h0000517C; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
                18: r = 32'h00000A2F; 19: r = 32'h00000517; 20: r = 32'h0000028B;
                21: r = 32'h00000145; 22: r = 32'h000000A2; 23: r = 32'h00000051;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        begin
            if (v > 64'sd32767)
                return 16'sd32767;
            else if (v < -64'sd32768)
                return -16'sd32768;
            else
                return v[15:0];
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/rfmc_cordic.sv
`default_nettype none
// pipelined cordic, one stage register per iteration; rotation or vectoring
module rfmc_cordic
    import rfmc_pkg::*;
#(
    parameter int STAGES = 16,
    parameter int XW = 42,
    parameter bit VECTORING = 1'b0
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic signed [XW-1:0]  x_in,
    input  wire logic signed [XW-1:0]  y_in,
    input  wire logic [31:0]           z_in,
    output logic signed [XW-1:0]       x_out,
    output logic signed [XW-1:0]       y_out,
    output logic [31:0]                z_out
);
    localparam int N = (STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : STAGES;

    logic signed [XW-1:0] x_reg [0:N];
    logic signed [XW-1:0] y_reg [0:N];
    logic [31:0]          z_reg [0:N];

    always_comb
    begin
        x_reg[0] = x_in;
        y_reg[0] = y_in;
        z_reg[0] = z_in;
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic dir_pos;
        assign dir_pos = VECTORING ? !y_reg[i][XW-1] : !z_reg[i][31];
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (dir_pos)
                begin
                    if (VECTORING)
                    begin
                        x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] + atan_entry(i);
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] - atan_entry(i);
                    end
                end
                else
                begin
                    if (VECTORING)
                    begin
                        x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] - atan_entry(i);
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] + atan_entry(i);
                    end
                end
            end
        end
    end

    logic unused_rst;
    assign unused_rst = rst_n;
    assign x_out = x_reg[N];
    assign y_out = y_reg[N];
    assign z_out = z_reg[N];
endmodule
`default_nettype wire

>>> rtl/robot_frame_motion_command.sv
`default_nettype none
// Robot-frame motion command. Each word carries a pose, a drive target and
// a point to face; the block returns robot-frame velocities (Q8.8), a turn
// rate (Q8.8) from the wrapped heading error, and the kick power. Words are
// independent: one word is taken every cycle while the pipe advances. The
// pipe is built from the two unrolled cordic pipelines (rotation of the drive
// offset, vectoring of the face offset) running side by side, plus two entry
// stages, four stages of gain compensation and scaling, and the output
// register. The whole pipe advances when the output register is free or
// being read, so a stall holds every stage. Gains and kick power are written
// over an APB-style port at byte addresses 0..16.
module robot_frame_motion_command
    import rfmc_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_word_t    in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_word_t        out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    // offset width: coord difference plus 16 fraction bits plus cordic growth
    localparam int DW = COORD_WIDTH + 1;
    localparam int XW = DW + 16 + 3;
    localparam int N  = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
    localparam int LAT = N + 6;

    // ---------------- configuration registers
    logic [15:0] move_plain_reg, move_kick_reg, turn_plain_reg, turn_kick_reg;
    logic [7:0]  kick_power_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_plain_reg <= 16'd57;
            move_kick_reg  <= 16'd655;
            turn_plain_reg <= 16'd256;
            turn_kick_reg  <= 16'd2560;
            kick_power_reg <= 8'd96;
        end
        else if (wr_en && paddr[1:0] == 2'b00)
        begin
            unique case (reg_idx)
                REG_MOVE_PLAIN: move_plain_reg <= pwdata[15:0];
                REG_MOVE_KICK:  move_kick_reg  <= pwdata[15:0];
                REG_TURN_PLAIN: turn_plain_reg <= pwdata[15:0];
                REG_TURN_KICK:  turn_kick_reg  <= pwdata[15:0];
                REG_KICK_POWER: kick_power_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_MOVE_PLAIN: prdata = {16'd0, move_plain_reg};
            REG_MOVE_KICK:  prdata = {16'd0, move_kick_reg};
            REG_TURN_PLAIN: prdata = {16'd0, turn_plain_reg};
            REG_TURN_KICK:  prdata = {16'd0, turn_kick_reg};
            REG_KICK_POWER: prdata = {24'd0, kick_power_reg};
            default:        prdata = '0;
        endcase
    end

    // ---------------- pipeline control: whole pipe stalls together
    logic       adv;
    logic [LAT-1:0] vld_reg;
    logic       out_valid_reg;
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[LAT-2:0], in_valid};
            out_valid_reg <= vld_reg[LAT-1];
        end
    end
    assign out_valid = out_valid_reg;

    // side data that rides along with the cordic: heading, kick, team, zero flag
    typedef struct packed {
        logic [15:0] head;
        logic        kick;
        logic        team;
        logic        face_zero;
    } side_t;
    side_t side_reg [0:LAT-1];

    // ---------------- stage 0: offsets
    logic signed [DW-1:0] dx_reg, dy_reg, lx_reg, ly_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg <= DW'($signed(in_data.goal_x[COORD_WIDTH-1:0]))
                      - DW'($signed(in_data.robot_x[COORD_WIDTH-1:0]));
            dy_reg <= DW'($signed(in_data.goal_y[COORD_WIDTH-1:0]))
                      - DW'($signed(in_data.robot_y[COORD_WIDTH-1:0]));
            lx_reg <= DW'($signed(in_data.face_x[COORD_WIDTH-1:0]))
                      - DW'($signed(in_data.robot_x[COORD_WIDTH-1:0]));
            ly_reg <= DW'($signed(in_data.face_y[COORD_WIDTH-1:0]))
                      - DW'($signed(in_data.robot_y[COORD_WIDTH-1:0]));
            side_reg[0] <= '{head: in_data.robot_heading, kick: in_data.kick_request,
                             team: in_data.team_yellow, face_zero: 1'b0};
        end
    end

    // ---------------- stage 1: quadrant pre-rotation for both cordics
    logic signed [XW-1:0] rx0_reg, ry0_reg, vx0_reg, vy0_reg;
    logic [31:0]          rz0_reg, vz0_reg;
    logic [31:0]          zrot;
    logic signed [XW-1:0] dxw, dyw, lxw, lyw;
    assign zrot = 32'd0 - {side_reg[0].head, 16'd0};
    // offsets in Q16 millimetres
    assign dxw  = XW'($signed({dx_reg, 16'd0}));
    assign dyw  = XW'($signed({dy_reg, 16'd0}));
    assign lxw  = XW'($signed({lx_reg, 16'd0}));
    assign lyw  = XW'($signed({ly_reg, 16'd0}));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (zrot[31] != zrot[30])
            begin
                rx0_reg <= -dxw;
                ry0_reg <= -dyw;
                rz0_reg <= zrot + 32'h80000000;
            end
            else
            begin
                rx0_reg <= dxw;
                ry0_reg <= dyw;
                rz0_reg <= zrot;
            end
            if (lx_reg < 0)
            begin
                vx0_reg <= -lxw;
                vy0_reg <= -lyw;
                vz0_reg <= 32'h80000000;
            end
            else
            begin
                vx0_reg <= lxw;
                vy0_reg <= lyw;
                vz0_reg <= 32'd0;
            end
            side_reg[1] <= '{head: side_reg[0].head, kick: side_reg[0].kick,
                             team: side_reg[0].team,
                             face_zero: (lx_reg == 0) && (ly_reg == 0)};
        end
    end

    logic signed [XW-1:0] rx_c, ry_c, vx_c, vy_c;
    logic [31:0]          rz_c, vz_c;

    rfmc_cordic #(.STAGES(CORDIC_STAGES), .XW(XW), .VECTORING(1'b0)) u_rot (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .x_in(rx0_reg), .y_in(ry0_reg), .z_in(rz0_reg),
        .x_out(rx_c), .y_out(ry_c), .z_out(rz_c)
    );
    rfmc_cordic #(.STAGES(CORDIC_STAGES), .XW(XW), .VECTORING(1'b1)) u_vec (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .x_in(vx0_reg), .y_in(vy0_reg), .z_in(vz0_reg),
        .x_out(vx_c), .y_out(vy_c), .z_out(vz_c)
    );

    // residual angle of the rotation and vector length are not needed
    logic unused_cordic;
    assign unused_cordic = ^{rz_c, vx_c, vy_c};

    for (genvar s = 2; s < N + 2; s++) begin : g_side
        always_ff @(posedge clk)
        begin
            if (adv)
                side_reg[s] <= side_reg[s-1];
        end
    end

    // ---------------- stage N+2: gain compensation and heading error
    localparam int PW = XW + 18;
    logic signed [PW-1:0]  px_reg, py_reg;
    logic signed [31:0]    err_reg;
    side_t                 sa;
    assign sa = side_reg[N+1];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg  <= PW'(rx_c) * PW'(INV_GAIN_Q16);
            py_reg  <= PW'(ry_c) * PW'(INV_GAIN_Q16);
            err_reg <= $signed(vz_c - {sa.head, 16'd0});
            side_reg[N+2] <= sa;
        end
    end

    // ---------------- stage N+3: gain select, error to radians
    logic signed [XW-1:0]  cx_reg, cy_reg;
    logic signed [63:0]    radp_reg;
    logic [15:0]           mg_reg, tg_reg;
    side_t                 sb;
    assign sb = side_reg[N+2];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg   <= XW'(px_reg >>> 16);
            cy_reg   <= XW'(py_reg >>> 16);
            radp_reg <= 64'(err_reg) * 64'(PI_Q29);
            mg_reg   <= sb.kick ? move_kick_reg : move_plain_reg;
            tg_reg   <= sb.kick ? turn_kick_reg : turn_plain_reg;
            side_reg[N+3] <= sb;
        end
    end

    // ---------------- stage N+4: velocity products, radians rounded
    localparam int VW = XW + 17;
    logic signed [VW-1:0] vxp_reg, vyp_reg;
    logic signed [19:0]   rad_reg;
    logic [15:0]          tg2_reg;
    logic signed [63:0]   rad_full;
    side_t                sc;
    assign sc = side_reg[N+3];
    assign rad_full = (radp_reg + (64'sd1 <<< 43)) >>> 44;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vxp_reg <= VW'(cx_reg) * $signed({1'b0, mg_reg});
            vyp_reg <= VW'(cy_reg) * $signed({1'b0, mg_reg});
            rad_reg <= rad_full[19:0];
            tg2_reg <= tg_reg;
            side_reg[N+4] <= sc;
        end
    end

    // ---------------- stage N+5: turn product, velocity round and saturate
    logic signed [15:0] vf_reg, vs_reg;
    logic signed [36:0] tp_reg;
    side_t              sd;
    logic signed [63:0] vxr, vyr;
    assign sd  = side_reg[N+4];
    assign vxr = 64'((vxp_reg + (VW'(1) <<< 23)) >>> 24);
    assign vyr = 64'((vyp_reg + (VW'(1) <<< 23)) >>> 24);
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vf_reg <= sat16(vxr);
            vs_reg <= sat16(vyr);
            tp_reg <= 37'(rad_reg) * $signed({1'b0, tg2_reg});
            side_reg[N+5] <= sd;
        end
    end

    // ---------------- output word register
    out_word_t          out_reg;
    side_t              se;
    logic signed [63:0] tr;
    assign se = side_reg[N+5];
    assign tr = 64'((tp_reg + 37'sd32768) >>> 16);
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.vel_forward <= vf_reg;
            out_reg.vel_side    <= vs_reg;
            out_reg.turn_rate   <= se.face_zero ? 16'sd0 : sat16(tr);
            out_reg.kick_power  <= se.kick ? kick_power_reg : 8'd0;
            out_reg.team_out    <= se.team;
        end
    end
    assign out_data = out_reg;

    // ---------------- checks
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");
    a_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted word lost at entry");
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(out_data))
        else $error("output word has unknown bits");
endmodule
`default_nettype wire

>>> tb/robot_frame_motion_command_checker.sv
module robot_frame_motion_command_checker
    import rfmc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_word_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_word_t out_data,
    input  logic      psel,
    input  logic      penable,
    input  logic      pwrite,
    input  logic      pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output int        fail_count,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES = 16;

    // shadow copy of the gain registers
    logic [15:0] gain_move_plain, gain_move_kick, gain_turn_plain, gain_turn_kick;
    logic [7:0]  kick_level;

    out_word_t command_queue[$];

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic logic [31:0] arctan_step(int i);
        logic [31:0] t[24] = '{32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53,
            32'h00145F2E, 32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3,
            32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F,
            32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};
        return t[i];
    endfunction

    function automatic out_word_t motion_command(in_word_t w);
        longint x, y, nx, lx, ly, mg, tg, err, rad, turn;
        logic [31:0] z, h32, ang;
        logic kick;
        out_word_t r;
        kick = w.kick_request;
        mg = kick ? gain_move_kick : gain_move_plain;
        tg = kick ? gain_turn_kick : gain_turn_plain;
        h32 = {w.robot_heading, 16'h0};
        x = (longint'(w.goal_x) - longint'(w.robot_x)) * 65536;
        y = (longint'(w.goal_y) - longint'(w.robot_y)) * 65536;
        // rotate drive offset by minus heading
        z = 32'd0 - h32;
        if (z[31:30] == 2'd1 || z[31:30] == 2'd2)
        begin
            x = -x;
            y = -y;
            z = z + 32'h80000000;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            if (!z[31])
            begin
                nx = x - floor_shr(y, i);
                y = y + floor_shr(x, i);
                z = z - arctan_step(i);
            end
            else
            begin
                nx = x + floor_shr(y, i);
                y = y - floor_shr(x, i);
                z = z + arctan_step(i);
            end
            x = nx;
        end
        x = floor_shr(x * 39797, 16);
        y = floor_shr(y * 39797, 16);
        r.vel_forward = 16'(clip16(floor_shr(x * mg + (64'sd1 << 23), 24)));
        r.vel_side = 16'(clip16(floor_shr(y * mg + (64'sd1 << 23), 24)));
        // heading error from vectoring cordic
        turn = 0;
        lx = longint'(w.face_x) - longint'(w.robot_x);
        ly = longint'(w.face_y) - longint'(w.robot_y);
        if (lx != 0 || ly != 0)
        begin
            x = lx * 65536;
            y = ly * 65536;
            ang = 0;
            if (x < 0)
            begin
                x = -x;
                y = -y;
                ang = 32'h80000000;
            end
            for (int i = 0; i < STAGES; i++)
            begin
                if (y >= 0)
                begin
                    nx = x + floor_shr(y, i);
                    y = y - floor_shr(x, i);
                    ang = ang + arctan_step(i);
                end
                else
                begin
                    nx = x - floor_shr(y, i);
                    y = y + floor_shr(x, i);
                    ang = ang - arctan_step(i);
                end
                x = nx;
            end
            err = longint'($signed(ang - h32));
            rad = floor_shr(err * 64'sd1686629713 + (64'sd1 << 43), 44);
            turn = clip16(floor_shr(rad * tg + (64'sd1 << 15), 16));
        end
        r.turn_rate = 16'(turn);
        r.kick_power = kick ? kick_level : 8'd0;
        r.team_out = w.team_yellow;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_move_plain <= 16'd57;
            gain_move_kick <= 16'd655;
            gain_turn_plain <= 16'd256;
            gain_turn_kick <= 16'd2560;
            kick_level <= 8'd96;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_MOVE_PLAIN: gain_move_plain <= pwdata[15:0];
                    REG_MOVE_KICK:  gain_move_kick <= pwdata[15:0];
                    REG_TURN_PLAIN: gain_turn_plain <= pwdata[15:0];
                    REG_TURN_KICK:  gain_turn_kick <= pwdata[15:0];
                    REG_KICK_POWER: kick_level <= pwdata[7:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                command_queue.push_back(motion_command(in_data));
            if (out_valid && out_ready)
            begin
                out_word_t want;
                if (command_queue.size() == 0)
                    report_mismatch("unexpected word", 1, 0);
                else
                begin
                    want = command_queue.pop_front();
                    if (out_data.vel_forward !== want.vel_forward)
                        report_mismatch("vel_forward", out_data.vel_forward, want.vel_forward);
                    if (out_data.vel_side !== want.vel_side)
                        report_mismatch("vel_side", out_data.vel_side, want.vel_side);
                    if (out_data.turn_rate !== want.turn_rate)
                        report_mismatch("turn_rate", out_data.turn_rate, want.turn_rate);
                    if (out_data.kick_power !== want.kick_power)
                        report_mismatch("kick_power", out_data.kick_power, want.kick_power);
                    if (out_data.team_out !== want.team_out)
                        report_mismatch("team_out", out_data.team_out, want.team_out);
                end
            end
        end
        pending = command_queue.size();
    end
endmodule

>>> tb/robot_frame_motion_command_test.sv
module robot_frame_motion_command_test;
    import rfmc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    in_word_t in_data;
    out_word_t out_data;
    logic psel, penable, pwrite, pready;
    logic [4:0] paddr;
    logic [31:0] pwdata, prdata;
    int fail_count, pending;
    int idle_cycles;
    bit long_hold;   // receiver holds off while this is set

    robot_frame_motion_command dut (.*);

    robot_frame_motion_command_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // watchdog: cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off to back up the pipe
    initial
    begin
        int gap;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
                out_ready <= 0;
            else if (out_ready && !(out_valid))
                ;
            else
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
                if (gap == 0)
                    out_ready <= 1;
                else
                begin
                    out_ready <= 0;
                    repeat (gap - 1) @(negedge clk);
                    out_ready <= 1;
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    // offer one word and hold it until taken; gap drawn per word
    task automatic send_word(in_word_t w, bit no_gap);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5));
        if (gap != 0)
        begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1;
        in_data <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 40)) - 16'd20;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        w = in_word_t'(raw[$bits(in_word_t)-1:0]);
        w.robot_x = pick_coord();
        w.robot_y = pick_coord();
        w.goal_x = pick_coord();
        w.goal_y = pick_coord();
        if ($urandom_range(0, 9) == 0)
        begin
            // face point on the robot
            w.face_x = w.robot_x;
            w.face_y = w.robot_y;
        end
        else
        begin
            w.face_x = pick_coord();
            w.face_y = pick_coord();
        end
        if ($urandom_range(0, 4) == 0)
            w.robot_heading = 16'({$urandom_range(0, 7), 13'h0});
        return w;
    endfunction

    task automatic wait_idle();
        in_valid <= 0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_gains(logic [15:0] mp, logic [15:0] mk, logic [15:0] tp,
                             logic [15:0] tk, logic [7:0] kp);
        write_reg(REG_MOVE_PLAIN, 32'(mp));
        write_reg(REG_MOVE_KICK, 32'(mk));
        write_reg(REG_TURN_PLAIN, 32'(tp));
        write_reg(REG_TURN_KICK, 32'(tk));
        write_reg(REG_KICK_POWER, 32'(kp));
    endtask

    initial
    begin
        in_word_t w;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        long_hold = 0;
        idle_cycles = 0;
        repeat (5) @(negedge clk);
        rst_n = 1;

        // directed words at reset gains
        w = '0;
        send_word(w, 0);                        // all zero, face on robot
        w = '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 1};
        send_word(w, 0);
        w = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 0};
        send_word(w, 0);
        // error exactly half a turn: face along -x, heading zero
        w = '{16'h0, 16'h0, 16'h0, 16'd1000, 16'h0, -16'sd500, 16'h0, 0, 1};
        send_word(w, 0);
        w.kick_request = 1;
        send_word(w, 0);
        // face along +x, heading pi
        w = '{16'h0, 16'h0, 16'h8000, 16'd300, -16'sd300, 16'd700, 16'h0, 1, 0};
        send_word(w, 0);
        for (int q = 0; q < 8; q++)
        begin
            w = '{16'd10, -16'sd10, 16'(q * 8192), 16'd2000, 16'd500, 16'd10, 16'd90, q[0], q[1]};
            send_word(w, 0);
        end
        wait_idle();

        // all-ones gains, then all-zero gains, then mid settings, later back to reset values
        set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        repeat (300) send_word(random_word(), 0);
        wait_idle();
        set_gains(16'h0, 16'h0, 16'h0, 16'h0, 8'h0);
        repeat (150) send_word(random_word(), 0);
        wait_idle();
        set_gains(16'h1234, 16'h00FF, 16'h0100, 16'h8000, 8'hA5);
        repeat (300) send_word(random_word(), 0);

        // long receiver hold-off while words keep coming
        wait_idle();
        fork
            begin
                long_hold = 1;
                repeat (200) @(negedge clk);
                long_hold = 0;
            end
            repeat (60) send_word(random_word(), 1);
        join
        wait_idle();
        set_gains(16'd57, 16'd655, 16'd256, 16'd2560, 8'd96);
        repeat (400) send_word(random_word(), 0);
        wait_idle();

        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

>>> files.f
rtl/rfmc_pkg.sv
rtl/rfmc_cordic.sv
rtl/robot_frame_motion_command.sv
tb/robot_frame_motion_command_checker.sv
tb/robot_frame_motion_command_test.sv
